// ===== hdl/ttab_pkg.sv =====
// Package for the touch tap and auto backlight block.
// Holds sequencer states, event codes, register indexes and timing constants.
// No dependencies.
package ttab_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_POINT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_POINT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FLOOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CEIL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR12 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MODE   = 3'd6;

    localparam logic [31:0] TAP_MS   = 32'd500;
    localparam logic [31:0] COUNT_MS = 32'd1200;
    localparam logic [31:0] RESET_MS = 32'd5000;
    localparam logic [31:0] SEC_MS   = 32'd1000;

    localparam logic [8:0]  SCREEN_WIDTH_RST = 9'd320;
    localparam logic [11:0] BRIGHT_RST       = 12'd200;
    localparam logic [11:0] DARK_RST         = 12'd3400;
    localparam logic [7:0]  FLOOR_RST        = 8'd10;
    localparam logic [7:0]  CEIL_RST         = 8'd255;
    localparam int          AVG_START        = 2000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOUCH,
        ST_SEL,
        ST_AVG_DIV,
        ST_AVG_UPD,
        ST_LVL_PREP,
        ST_LVL_MUL,
        ST_LVL_DIV,
        ST_LVL_FIN,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_COUNTDOWN,
        EV_RESET,
        EV_HOUR,
        EV_MODE,
        EV_CANCEL
    } event_t;

    typedef enum logic [1:0] {
        MODE_AUTO,
        MODE_MAX,
        MODE_MED,
        MODE_MIN
    } mode_t;

    function automatic logic [7:0] fixed_level(input logic [1:0] m);
        logic [7:0] lv;
        unique case (m)
            MODE_MAX: lv = 8'd255;
            MODE_MED: lv = 8'd110;
            MODE_MIN: lv = 8'd25;
            default:  lv = 8'd0;
        endcase
        return lv;
    endfunction

endpackage

// ===== hdl/touch_tap_and_auto_backlight.sv =====
// Touch tap classifier and automatic backlight controller, top level; depends on ttab_pkg.
// Items run TOUCH, DONE (touch-only); TOUCH, SEL, CMP, DONE (fixed mode); automatic mode
// adds AVG_DIV, AVG_UPD, LVL_PREP, LVL_MUL, the 8-step shift-subtract level divider and
// LVL_FIN (LVL_PREP goes to CMP if calibration points are equal). s_tready is high only
// in idle, so items never overlap; an untaken result holds the last state until m_tready.
// Reset (aresetn low, synchronous): registers to defaults, average 2000.0, no level.
module touch_tap_and_auto_backlight #(
    parameter int FRAC_BITS = ttab_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] pressed, [9:1] touch_x, [41:10] now_ms, [53:42] light_raw
    input  logic [55:0]                      s_tdata,
    // [0] cmd
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] event_res, [5:3] countdown_secs, [13:6] level, [14] hour12, [16:15] mode
    output logic [23:0]                      m_tdata,
    // [0] level_valid
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ttab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttab_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = 12 + FRAC_BITS;
    localparam int DW = AW + 1;
    localparam int PW = AW + 8;
    localparam int QW = FRAC_BITS + 9;
    localparam int CW = $clog2(QW + 1);
    // divide by ten as multiply by ceil(2^RK / 10), exact for dividends below 2^AW
    localparam int RK = AW + 4;
    localparam logic [AW:0] RECIP10 = (AW+1)'(((64'd1 << RK) + 64'd9) / 64'd10);

    ttab_pkg::state_t state_reg, state_next;

    logic [8:0]  scr_w_reg;
    logic [11:0] bright_reg, dark_reg;
    logic [7:0]  floor_reg, ceil_reg;

    logic        in_cmd_reg, in_pressed_reg;
    logic [8:0]  in_x_reg;
    logic [31:0] in_now_reg;
    logic [11:0] in_raw_reg;

    logic        was_down_reg, was_down_next;
    logic [31:0] began_reg, began_next;
    logic [8:0]  column_reg, column_next;
    logic [AW-1:0] avg_reg, avg_next;
    logic signed [8:0] last_reg, last_next;
    logic        hour_reg, hour_next;
    logic [1:0]  mode_reg, mode_next;

    logic [2:0]  ev_reg, ev_next;
    logic [2:0]  secs_reg, secs_next;
    logic        lvl_valid_reg, lvl_valid_next;
    logic [7:0]  target_reg, target_next;
    logic        sign_reg, sign_next;
    logic [AW-1:0] diff_reg, diff_next;
    logic [AW-1:0] den_reg, den_next;

    logic [PW-1:0] rem_reg, rem_next;
    logic [PW-1:0] sv_reg, sv_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;
    logic        out_user_reg, out_user_next;

    logic          in_acc, out_free, div_ge, div_last;
    logic [PW-1:0] div_sub, prod;
    logic [2*AW:0] recip_prod;
    logic [31:0]   held, left_ms;
    logic signed [DW-1:0] d_val, d_mag, num_v, den_v, nn, nd;
    logic [AW-1:0] raw_f, bf, df;
    logic          span_neg;
    logic [7:0]    span_mag;
    logic signed [9:0] lvl_diff;
    logic [7:0]    lvl_out;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign div_ge   = rem_reg >= sv_reg;
    assign div_sub  = rem_reg - sv_reg;
    assign div_last = cnt_reg == CW'(1);

    assign recip_prod = (2*AW+1)'(rem_reg[AW-1:0]) * (2*AW+1)'(RECIP10);

    assign held    = in_now_reg - began_reg;
    assign left_ms = ttab_pkg::RESET_MS - held;

    assign raw_f = {in_raw_reg, {FRAC_BITS{1'b0}}};
    assign bf    = {bright_reg, {FRAC_BITS{1'b0}}};
    assign df    = {dark_reg, {FRAC_BITS{1'b0}}};
    assign d_val = $signed({1'b0, raw_f}) - $signed({1'b0, avg_reg});
    assign d_mag = d_val[DW-1] ? -d_val : d_val;
    assign num_v = $signed({1'b0, avg_reg}) - $signed({1'b0, bf});
    assign den_v = $signed({1'b0, df}) - $signed({1'b0, bf});
    assign nd    = den_v[DW-1] ? -den_v : den_v;
    assign nn    = den_v[DW-1] ? -num_v : num_v;

    assign span_neg = ceil_reg < floor_reg;
    assign span_mag = span_neg ? floor_reg - ceil_reg : ceil_reg - floor_reg;
    assign prod     = diff_reg * span_mag;

    assign lvl_diff = $signed({2'b00, target_reg}) - $signed({last_reg[8], last_reg});
    assign lvl_out  = last_reg[8] ? 8'd0 : last_reg[7:0];

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ttab_pkg::ST_IDLE: begin
                if (in_acc) state_next = ttab_pkg::ST_TOUCH;
            end
            ttab_pkg::ST_TOUCH: begin
                state_next = in_cmd_reg ? ttab_pkg::ST_SEL : ttab_pkg::ST_DONE;
            end
            ttab_pkg::ST_SEL: begin
                state_next = (mode_reg == ttab_pkg::MODE_AUTO) ? ttab_pkg::ST_AVG_DIV
                                                                : ttab_pkg::ST_CMP;
            end
            ttab_pkg::ST_AVG_DIV:  state_next = ttab_pkg::ST_AVG_UPD;
            ttab_pkg::ST_AVG_UPD:  state_next = ttab_pkg::ST_LVL_PREP;
            ttab_pkg::ST_LVL_PREP: begin
                state_next = (den_v == '0) ? ttab_pkg::ST_CMP : ttab_pkg::ST_LVL_MUL;
            end
            ttab_pkg::ST_LVL_MUL:  state_next = ttab_pkg::ST_LVL_DIV;
            ttab_pkg::ST_LVL_DIV: begin
                if (div_last) state_next = ttab_pkg::ST_LVL_FIN;
            end
            ttab_pkg::ST_LVL_FIN:  state_next = ttab_pkg::ST_CMP;
            ttab_pkg::ST_CMP:      state_next = ttab_pkg::ST_DONE;
            ttab_pkg::ST_DONE: begin
                if (out_free) state_next = ttab_pkg::ST_IDLE;
            end
            default: state_next = ttab_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        was_down_next  = was_down_reg;
        began_next     = began_reg;
        column_next    = column_reg;
        avg_next       = avg_reg;
        last_next      = last_reg;
        hour_next      = hour_reg;
        mode_next      = mode_reg;
        ev_next        = ev_reg;
        secs_next      = secs_reg;
        lvl_valid_next = lvl_valid_reg;
        target_next    = target_reg;
        sign_next      = sign_reg;
        diff_next      = diff_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        sv_next        = sv_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        unique case (state_reg)
            ttab_pkg::ST_TOUCH: begin
                ev_next        = ttab_pkg::EV_NONE;
                secs_next      = 3'd0;
                lvl_valid_next = 1'b0;
                was_down_next  = in_pressed_reg;
                if (in_pressed_reg && !was_down_reg) begin
                    began_next  = in_now_reg;
                    column_next = in_x_reg;
                end else if (in_pressed_reg) begin
                    if (held >= ttab_pkg::RESET_MS) begin
                        ev_next       = ttab_pkg::EV_RESET;
                        was_down_next = 1'b0;
                    end else if (held >= ttab_pkg::COUNT_MS) begin
                        ev_next = ttab_pkg::EV_COUNTDOWN;
                        priority if (left_ms >= 3 * ttab_pkg::SEC_MS) secs_next = 3'd4;
                        else if (left_ms >= 2 * ttab_pkg::SEC_MS)     secs_next = 3'd3;
                        else if (left_ms >= ttab_pkg::SEC_MS)         secs_next = 3'd2;
                        else                                          secs_next = 3'd1;
                    end
                end else if (was_down_reg) begin
                    if (held < ttab_pkg::TAP_MS) begin
                        if (column_reg < (scr_w_reg >> 1)) begin
                            hour_next = !hour_reg;
                            ev_next   = ttab_pkg::EV_HOUR;
                        end else begin
                            mode_next = mode_reg + 2'd1;
                            ev_next   = ttab_pkg::EV_MODE;
                        end
                    end else begin
                        ev_next = ttab_pkg::EV_CANCEL;
                    end
                end
            end
            ttab_pkg::ST_SEL: begin
                target_next = ttab_pkg::fixed_level(mode_reg);
                sign_next   = d_val[DW-1];
                rem_next    = PW'(d_mag[AW-1:0]) + PW'(5);
            end
            ttab_pkg::ST_AVG_DIV: begin
                q_next = recip_prod[RK +: QW];
            end
            ttab_pkg::ST_LVL_DIV: begin
                rem_next = div_ge ? div_sub : rem_reg;
                q_next   = {q_reg[QW-2:0], div_ge};
                sv_next  = sv_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
            end
            ttab_pkg::ST_AVG_UPD: begin
                avg_next = sign_reg ? avg_reg - AW'(q_reg) : avg_reg + AW'(q_reg);
            end
            ttab_pkg::ST_LVL_PREP: begin
                target_next = (!num_v[DW-1] && num_v != '0) ? floor_reg : ceil_reg;
                den_next    = nd[AW-1:0];
                if (nn[DW-1])     diff_next = nd[AW-1:0];
                else if (nn > nd) diff_next = '0;
                else              diff_next = AW'(nd - nn);
            end
            ttab_pkg::ST_LVL_MUL: begin
                rem_next = prod;
                sv_next  = PW'(den_reg) << 7;
                q_next   = '0;
                cnt_next = CW'(8);
            end
            ttab_pkg::ST_LVL_FIN: begin
                target_next = span_neg ? floor_reg - q_reg[7:0] : floor_reg + q_reg[7:0];
            end
            ttab_pkg::ST_CMP: begin
                if (lvl_diff > 10'sd2 || lvl_diff < -10'sd2) begin
                    last_next      = $signed({1'b0, target_reg});
                    lvl_valid_next = 1'b1;
                end
            end
            ttab_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_user_next  = lvl_valid_reg;
                    out_data_next  = {7'd0, mode_reg, hour_reg, lvl_out, secs_reg, ev_reg};
                end
            end
            default: ;
        endcase
    end

    assign s_tready  = state_reg == ttab_pkg::ST_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign cfg_ready = 1'b1;

    // start_hour12 and start_mode take effect only at reset, where they hold
    // their reset value, so writes to them are accepted and dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg  <= ttab_pkg::SCREEN_WIDTH_RST;
            bright_reg <= ttab_pkg::BRIGHT_RST;
            dark_reg   <= ttab_pkg::DARK_RST;
            floor_reg  <= ttab_pkg::FLOOR_RST;
            ceil_reg   <= ttab_pkg::CEIL_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ttab_pkg::CFG_SCREEN_WIDTH: scr_w_reg  <= cfg_data[8:0];
                ttab_pkg::CFG_BRIGHT_POINT: bright_reg <= cfg_data;
                ttab_pkg::CFG_DARK_POINT:   dark_reg   <= cfg_data;
                ttab_pkg::CFG_LEVEL_FLOOR:  floor_reg  <= cfg_data[7:0];
                ttab_pkg::CFG_LEVEL_CEIL:   ceil_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ttab_pkg::ST_IDLE;
            was_down_reg  <= 1'b0;
            began_reg     <= '0;
            column_reg    <= '0;
            avg_reg       <= AW'(ttab_pkg::AVG_START) << FRAC_BITS;
            last_reg      <= -9'sd1;
            hour_reg      <= 1'b0;
            mode_reg      <= ttab_pkg::MODE_AUTO;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            was_down_reg  <= was_down_next;
            began_reg     <= began_next;
            column_reg    <= column_next;
            avg_reg       <= avg_next;
            last_reg      <= last_next;
            hour_reg      <= hour_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            in_cmd_reg     <= s_tuser;
            in_pressed_reg <= s_tdata[0];
            in_x_reg       <= s_tdata[9:1];
            in_now_reg     <= s_tdata[41:10];
            in_raw_reg     <= s_tdata[53:42];
        end
        ev_reg        <= ev_next;
        secs_reg      <= secs_next;
        lvl_valid_reg <= lvl_valid_next;
        target_reg    <= target_next;
        sign_reg      <= sign_next;
        diff_reg      <= diff_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        sv_reg        <= sv_next;
        q_reg         <= q_next;
        cnt_reg       <= cnt_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> state_reg == ttab_pkg::ST_TOUCH)
        else $error("accepted item did not start the sequencer");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ttab_pkg::ST_LVL_DIV |-> cnt_reg != '0)
        else $error("divider step count ran out");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ttab_pkg::ST_DONE && out_free) |=> m_tvalid)
        else $error("finished item not presented");

    a_secs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[2:0] == ttab_pkg::EV_COUNTDOWN)
                      ? (m_tdata[5:3] >= 3'd1 && m_tdata[5:3] <= 3'd4)
                      : (m_tdata[5:3] == 3'd0)))
        else $error("countdown seconds inconsistent with event");
`endif

endmodule
